@@ hw/rtl/bbd_pkg.sv @@
// Shared types, constants and conversion functions of the BCD display formatter.
package bbd_pkg;

   localparam int NumDigits = 5;
   localparam int ValueWidth = 16;
   localparam int BcdWidth = 4 * NumDigits;
   localparam int HalfWidth = ValueWidth / 2;
   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] AsciiZero = 8'h30;
   localparam logic [7:0] AsciiSpace = 8'h20;

   typedef enum logic [1:0] {
      ALIGN_ZERO   = 2'd0,
      ALIGN_RIGHT  = 2'd1,
      ALIGN_LEFT   = 2'd2,
      ALIGN_CENTER = 2'd3
   } align_type;

   typedef logic [BcdWidth-1:0] bcd_type;

   // One double-dabble step: correct every digit that would overflow on the
   // next doubling, then shift the next binary bit in at the bottom.
   function automatic bcd_type dabble_step(input bcd_type bcd, input logic bit_in);
      bcd_type fixed;
      fixed = bcd;
      for (int d = 0; d < NumDigits; d++) begin
         if (fixed[4*d +: 4] >= 4'd5) begin
            fixed[4*d +: 4] = fixed[4*d +: 4] + 4'd3;
         end
      end
      return {fixed[BcdWidth-2:0], bit_in};
   endfunction

   // Eight shift steps, most significant bit of the byte first.
   function automatic bcd_type dabble_byte(input bcd_type bcd,
                                           input logic [HalfWidth-1:0] bits);
      bcd_type acc;
      acc = bcd;
      for (int i = HalfWidth - 1; i >= 0; i--) begin
         acc = dabble_step(acc, bits[i]);
      end
      return acc;
   endfunction

endpackage

@@ hw/rtl/bbd_if.sv @@
// Handshake channel interfaces for values, display results and the mode register.
interface bbd_req_if;
   logic                              valid;
   logic                              ready;
   logic [bbd_pkg::ValueWidth-1:0]    value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface bbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_0;
   logic [7:0] char_1;
   logic [7:0] char_2;
   logic [7:0] char_3;
   logic [7:0] char_4;
   logic [2:0] digit_count;

   modport source (output valid, output char_0, output char_1, output char_2,
                   output char_3, output char_4, output digit_count, input ready);
   modport sink (input valid, input char_0, input char_1, input char_2,
                 input char_3, input char_4, input digit_count, output ready);
endinterface

interface bbd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/bbd_front.sv @@
// Front end: accepts values and converts them to BCD in two pipelined halves.
module bbd_front (
   input  logic                    clock,
   input  logic                    reset,
   bbd_req_if.sink                 req,
   output logic                    push_valid,
   output bbd_pkg::bcd_type        push_data,
   input  logic                    push_ready
);

   localparam int HW = bbd_pkg::HalfWidth;

   logic                 s1_valid_ff, s1_valid_in;
   bbd_pkg::bcd_type     s1_bcd_ff, s1_bcd_in;
   logic [HW-1:0]        s1_low_ff, s1_low_in;
   logic                 s2_valid_ff, s2_valid_in;
   bbd_pkg::bcd_type     s2_bcd_ff, s2_bcd_in;
   logic                 adv2;
   logic                 adv1;

   assign adv2 = !s2_valid_ff || push_ready;
   assign adv1 = !s1_valid_ff || adv2;
   assign req.ready = adv1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_bcd_in   = s1_bcd_ff;
      s1_low_in   = s1_low_ff;
      s2_valid_in = s2_valid_ff;
      s2_bcd_in   = s2_bcd_ff;
      if (adv1) begin
         s1_valid_in = req.valid;
         s1_bcd_in   = bbd_pkg::dabble_byte('0, req.value[bbd_pkg::ValueWidth-1 -: HW]);
         s1_low_in   = req.value[HW-1:0];
      end
      if (adv2) begin
         s2_valid_in = s1_valid_ff;
         s2_bcd_in   = bbd_pkg::dabble_byte(s1_bcd_ff, s1_low_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_bcd_ff <= s1_bcd_in;
      s1_low_ff <= s1_low_in;
      s2_bcd_ff <= s2_bcd_in;
   end

   assign push_valid = s2_valid_ff;
   assign push_data  = s2_bcd_ff;

endmodule

@@ hw/rtl/bbd_queue.sv @@
// Short queue of converted BCD words between the front end and the formatter.
module bbd_queue #(
   parameter int DEPTH = bbd_pkg::QueueDepthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  bbd_pkg::bcd_type        push_data,
   output logic                    push_ready,
   output logic                    pop_valid,
   output bbd_pkg::bcd_type        pop_data,
   input  logic                    pop_ready
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);

   bbd_pkg::bcd_type        entry_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]     count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = count_ff != CntWidth'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/bbd_back.sv @@
// Back end: lays out the BCD digits as ASCII characters and holds the result item.
module bbd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  bbd_pkg::align_type      align_mode,
   input  logic                    pop_valid,
   input  bbd_pkg::bcd_type        pop_data,
   output logic                    pop_ready,
   bbd_rsp_if.source               rsp
);

   localparam int N = bbd_pkg::NumDigits;

   logic [3:0]   dig [N];
   logic [2:0]   lead;
   logic [2:0]   num_dig;
   logic [2:0]   start;
   logic [3:0]   src;
   logic [7:0]   disp [N];
   logic         found;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   char_ff [N];
   logic [2:0]   count_ff;
   logic         take;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign take = pop_valid && pop_ready;

   always_comb begin
      for (int d = 0; d < N; d++) begin
         dig[d] = pop_data[4*(N-1-d) +: 4];
      end
      // Leading zeros; a zero value keeps its last digit as significant.
      lead  = 3'(N - 1);
      found = 1'b0;
      for (int d = 0; d < N - 1; d++) begin
         if (!found && dig[d] != 4'd0) begin
            lead  = 3'(d);
            found = 1'b1;
         end
      end
      num_dig = 3'(N) - lead;
      case (align_mode)
         bbd_pkg::ALIGN_RIGHT:  start = lead;
         bbd_pkg::ALIGN_LEFT:   start = 3'd0;
         bbd_pkg::ALIGN_CENTER: start = lead >> 1;
         default:               start = 3'd0;
      endcase
      for (int p = 0; p < N; p++) begin
         src = 4'(p) + {1'b0, lead} - {1'b0, start};
         if (align_mode == bbd_pkg::ALIGN_ZERO) begin
            disp[p] = bbd_pkg::AsciiZero + {4'd0, dig[p]};
         end else if (3'(p) >= start && 4'(p) < {1'b0, start} + {1'b0, num_dig}) begin
            disp[p] = bbd_pkg::AsciiZero + {4'd0, dig[src[2:0]]};
         end else begin
            disp[p] = bbd_pkg::AsciiSpace;
         end
      end
      rsp_valid_in = take ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         for (int p = 0; p < N; p++) begin
            char_ff[p] <= disp[p];
         end
         count_ff <= num_dig;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.char_0      = char_ff[0];
   assign rsp.char_1      = char_ff[1];
   assign rsp.char_2      = char_ff[2];
   assign rsp.char_3      = char_ff[3];
   assign rsp.char_4      = char_ff[4];
   assign rsp.digit_count = count_ff;

endmodule

@@ hw/rtl/binary_to_bcd_display_formatter_unit.sv @@
// Top level of the binary to BCD display formatter with its mode register.
// The unit takes one 16-bit value per cycle until a stalled output fills the queue, and
// returns five ASCII characters and the significant digit count; a result passes
// through the two conversion stages, the queue and the result register. The binary
// to BCD conversion runs as two pipeline stages of eight shift-and-correct steps
// each, which sets the cycle time, and a queue of QUEUE_DEPTH entries lets the
// converter keep accepting while the output is held. The alignment mode is read by
// the output formatter, so it is to be written only while no items are in flight.
module binary_to_bcd_display_formatter_unit #(
   parameter int QUEUE_DEPTH = bbd_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   bbd_req_if.sink     req,
   bbd_rsp_if.source   rsp,
   bbd_csr_if.sink     csr
);

   bbd_pkg::align_type   align_mode_ff, align_mode_in;
   logic                 push_valid;
   logic                 push_ready;
   bbd_pkg::bcd_type     push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   bbd_pkg::bcd_type     pop_data;

   assign csr.ready = 1'b1;
   assign align_mode_in = csr.valid ? bbd_pkg::align_type'(csr.data) : align_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         align_mode_ff <= bbd_pkg::ALIGN_ZERO;
      end else begin
         align_mode_ff <= align_mode_in;
      end
   end

   bbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   bbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   bbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .align_mode (align_mode_ff),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready),
      .rsp        (rsp)
   );

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the binary to BCD display formatter unit.
`timescale 1ns / 100ps

module testbench;

   localparam int QuietLimit = 2000;
   localparam int LongHold = 60;
   localparam int RandomPhases = 10;
   localparam int PhaseItems = 125;

   typedef struct packed {
      logic [0:bbd_pkg::NumDigits-1][7:0] chars;
      logic [2:0]                         digit_count;
   } display_type;

   logic clock;
   logic reset;

   bbd_req_if req_bus ();
   bbd_rsp_if rsp_bus ();
   bbd_csr_if csr_bus ();

   binary_to_bcd_display_formatter_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   logic [bbd_pkg::ValueWidth-1:0] pending_values[$];
   display_type                    expected_displays[$];
   bbd_pkg::align_type             mode_now;
   bit                             idle_on;
   int                             hold_requests;
   int                             mismatch_count;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Lays out the significant digits of a value in the five-character field.
   function automatic display_type format_display(input logic [bbd_pkg::ValueWidth-1:0] v,
                                                  input bbd_pkg::align_type m);
      int          digs[bbd_pkg::NumDigits];
      int          rest;
      int          first;
      int          width;
      int          offset;
      int          i;
      display_type r;
      rest = v;
      for (i = bbd_pkg::NumDigits - 1; i >= 0; i--) begin
         digs[i] = rest % 10;
         rest = rest / 10;
      end
      first = 0;
      while (first < bbd_pkg::NumDigits - 1 && digs[first] == 0) begin
         first++;
      end
      width = bbd_pkg::NumDigits - first;
      case (m)
         bbd_pkg::ALIGN_RIGHT: begin
            offset = bbd_pkg::NumDigits - width;
         end
         bbd_pkg::ALIGN_CENTER: begin
            offset = (bbd_pkg::NumDigits - width) / 2;
         end
         default: begin
            offset = 0;
         end
      endcase
      for (i = 0; i < bbd_pkg::NumDigits; i++) begin
         r.chars[i] = (m == bbd_pkg::ALIGN_ZERO) ? 8'(bbd_pkg::AsciiZero + digs[i]) :
                                                    bbd_pkg::AsciiSpace;
      end
      if (m != bbd_pkg::ALIGN_ZERO) begin
         for (i = 0; i < width; i++) begin
            r.chars[offset + i] = 8'(bbd_pkg::AsciiZero + digs[first + i]);
         end
      end
      r.digit_count = 3'(width);
      return r;
   endfunction

   // Picks a value spread over the number of decimal digits, or, one time in six, any 16-bit value.
   function automatic logic [bbd_pkg::ValueWidth-1:0] pick_value();
      int n;
      int lo;
      int hi;
      n = $urandom_range(0, bbd_pkg::NumDigits);
      if (n == 0) begin
         return bbd_pkg::ValueWidth'($urandom);
      end
      lo = (n == 1) ? 0 : 10 ** (n - 1);
      hi = (n == bbd_pkg::NumDigits) ? 65535 : 10 ** n - 1;
      return bbd_pkg::ValueWidth'($urandom_range(hi, lo));
   endfunction

   // Value driver: keeps offering items from the pending queue, with random gaps while idle_on is set.
   always @(posedge clock) begin
      logic taken;
      int   send_gap;
      taken = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (taken) begin
            expected_displays.push_back(format_display(req_bus.value, mode_now));
         end
         if (!req_bus.valid || taken) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.value <= pending_values.pop_front();
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(1, 10);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted item and paces the ready signal.
   always @(posedge clock) begin
      display_type got;
      display_type want;
      int          hold_served;
      int          hold_left;
      int          stall_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_served = hold_requests;
         hold_left = 0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.chars = {rsp_bus.char_0, rsp_bus.char_1, rsp_bus.char_2,
                         rsp_bus.char_3, rsp_bus.char_4};
            got.digit_count = rsp_bus.digit_count;
            if (expected_displays.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected result \"%s\" count %0d", got.chars,
                           got.digit_count);
               end
            end else begin
               want = expected_displays.pop_front();
               if (got.chars != want.chars || got.digit_count != want.digit_count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected \"%s\" count %0d, got \"%s\" count %0d",
                              want.chars, want.digit_count, got.chars,
                              got.digit_count);
                  end
               end
            end
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LongHold;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Ends the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      int quiet;
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet == QuietLimit) begin
         $display("FAIL binary_to_bcd_display_formatter_unit");
         $finish;
      end
   end

   task automatic write_mode(input bbd_pkg::align_type m);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= m;
      do begin
         @(posedge clock);
      end while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      mode_now = m;
   endtask

   // Waits until every queued value has been sent and every result checked.
   task automatic drain();
      do begin
         @(posedge clock);
      end while (pending_values.size() != 0 || req_bus.valid ||
                 expected_displays.size() != 0);
   endtask

   task automatic run_directed(input bbd_pkg::align_type m,
                               input logic [bbd_pkg::ValueWidth-1:0] vals[]);
      write_mode(m);
      foreach (vals[k]) begin
         pending_values.push_back(vals[k]);
      end
      drain();
   endtask

   initial begin
      int p;
      int k;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      mode_now = bbd_pkg::ALIGN_ZERO;
      idle_on = 1'b1;
      hold_requests = 0;
      mismatch_count = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero counts as a single significant digit in every layout.
      run_directed(bbd_pkg::ALIGN_ZERO, '{16'd0, 16'd65535, 16'd1, 16'h8000, 16'h5555,
                                          16'hAAAA});
      run_directed(bbd_pkg::ALIGN_RIGHT, '{16'd0, 16'd9, 16'd10, 16'd12345});
      run_directed(bbd_pkg::ALIGN_LEFT, '{16'd0, 16'd99, 16'd100, 16'd9999});
      run_directed(bbd_pkg::ALIGN_CENTER, '{16'd0, 16'd999, 16'd1000, 16'd54321, 16'd1});

      for (p = 0; p < RandomPhases; p++) begin
         write_mode(bbd_pkg::align_type'($urandom_range(0, 3)));
         if (p >= RandomPhases - 2) begin
            idle_on = 1'b0;
         end
         for (k = 0; k < PhaseItems; k++) begin
            pending_values.push_back(pick_value());
         end
         // Hold the output back while values keep coming, so the unit backs up.
         if (p == 2 || p == 6) begin
            hold_requests++;
         end
         drain();
      end

      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && expected_displays.size() == 0) begin
         $display("PASS binary_to_bcd_display_formatter_unit");
      end else begin
         $display("FAIL binary_to_bcd_display_formatter_unit");
      end
      $finish;
   end

endmodule
